// ===== hdl/dgr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the unit-disk graph reachability block.
// Holds field widths, register indexes and reset values; depends on nothing.
package dgr_pkg;

   localparam int COORD_W = 11;                // signed point coordinate
   localparam int REG_W = 11;                  // width of every CSR
   localparam int CSR_IDX_W = 2;
   localparam int OP_W = COORD_W + 2;          // operand of the square unit
   localparam int SQ_W = 2 * OP_W + 1;         // sum of two squares
   localparam int DEFAULT_MAX_POINTS = 128;

   localparam logic [CSR_IDX_W-1:0] CSR_JUMP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ISLAND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BORDER = 2'd2;

   localparam logic [REG_W-1:0] RST_JUMP = 11'd0;
   localparam logic [REG_W-1:0] RST_ISLAND = 11'd120;
   localparam logic [REG_W-1:0] RST_BORDER = 11'd800;

endpackage

// ===== hdl/disk_graph_reachability.sv =====
`timescale 1ns / 1ps
// Top level of the unit-disk graph reachability block: point store, search
// stack, visited map and the sequencer around one shared square-sum unit.
// Depends on dgr_pkg.
//
// Usage:
// - req_* carries one point per item. Points load at one per cycle into the
//   point memory; a point arriving with the store full is dropped.
// - The item with req_tlast high adds its point and starts a depth-first
//   search. req_tready stays low until the answer has been taken.
// - rsp_* carries exactly one item per search: rsp_tdata[0] is high when a
//   point near the border is reachable from the island (or the island itself
//   reaches the border). rsp_tvalid holds until rsp_tready; the store and
//   visited map clear on that handshake and loading resumes.
// - csr_* writes jump distance, island radius and border half-size; write
//   only while no search is running. Unknown indexes are ignored.
// A search first squares the jump distance and the reach in the shared unit,
// then reads each unvisited start candidate or neighbor point, forms its square
// sum and compares it; a popped point is read back through the stack and point
// memory. The single square-sum unit with its registered memory read sets the
// pace. Reset empties the store and loads the CSR reset values.
module disk_graph_reachability
   import dgr_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,   // [10:0] pos_x, [21:11] pos_y, rest zero
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [0] escaped, rest zero
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [REG_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int PT_W = 2 * COORD_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT_J, ST_INIT_R, ST_INIT_JSQ, ST_INIT_RSQ,
      ST_S_SCAN, ST_S_WAIT, ST_S_SQ, ST_S_CMP,
      ST_POP, ST_POP_WAIT, ST_POP_RD,
      ST_T_SCAN, ST_T_WAIT, ST_T_SQ, ST_T_CMP
   } state_type;

   state_type                state_ff;
   logic                     rsp_valid_ff;
   logic                     escaped_ff;

   logic [REG_W-1:0]         jump_ff, island_ff, border_ff;
   logic [CNT_W-1:0]         count_ff, depth_ff, s_ff, t_ff;
   logic [MAX_POINTS-1:0]    vis_ff;
   logic signed [COORD_W-1:0] ux_ff, uy_ff;
   logic [SQ_W-1:0]          jsq_ff, rsq_ff;

   // shared square-sum unit
   logic signed [OP_W-1:0]   opx_ff, opy_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic signed [2*OP_W-1:0] px_in, py_in;

   // point memory
   logic [PT_W-1:0]          pmem [MAX_POINTS];
   logic [PT_W-1:0]          prd_ff;
   logic [IDX_W-1:0]         prd_addr;
   logic                     pwr_en;

   // stack memory
   logic [IDX_W-1:0]         smem [MAX_POINTS];
   logic [IDX_W-1:0]         srd_ff;
   logic                     swr_en;
   logic [IDX_W-1:0]         swr_data;

   logic signed [COORD_W-1:0] rd_x, rd_y;
   logic [COORD_W-1:0]       abs_x, abs_y;
   logic signed [OP_W-1:0]   lim;
   logic [REG_W:0]           reach;
   logic                     accept, at_edge;

   assign req_tready = (state_ff == ST_LOAD) && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, escaped_ff};

   assign rd_x = prd_ff[COORD_W-1:0];
   assign rd_y = prd_ff[PT_W-1:COORD_W];
   assign abs_x = rd_x[COORD_W-1] ? COORD_W'(-rd_x) : COORD_W'(rd_x);
   assign abs_y = rd_y[COORD_W-1] ? COORD_W'(-rd_y) : COORD_W'(rd_y);
   assign lim = OP_W'(signed'({2'b00, border_ff})) - OP_W'(signed'({2'b00, jump_ff}));
   // abs of -1024 wraps to 1024 as unsigned 11 bits, so compare unsigned
   assign at_edge = (OP_W'(signed'({2'b00, abs_x})) >= lim)
                 || (OP_W'(signed'({2'b00, abs_y})) >= lim);
   assign reach = {1'b0, jump_ff} + {1'b0, island_ff};

   assign px_in = opx_ff * opx_ff;
   assign py_in = opy_ff * opy_ff;

   // point memory address and write enable, stack write enable and data
   always_comb begin
      pwr_en = accept && (count_ff < MAX_CNT);
      case (state_ff)
         ST_S_SCAN: prd_addr = s_ff[IDX_W-1:0];
         ST_T_SCAN: prd_addr = t_ff[IDX_W-1:0];
         default:   prd_addr = srd_ff;
      endcase
      swr_en = 1'b0;
      swr_data = t_ff[IDX_W-1:0];
      if (state_ff == ST_S_CMP && sq_ff <= rsq_ff) begin
         swr_en = 1'b1;
         swr_data = s_ff[IDX_W-1:0];
      end else if (state_ff == ST_T_CMP && sq_ff <= jsq_ff && depth_ff < MAX_CNT) begin
         swr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pwr_en) begin
         pmem[count_ff[IDX_W-1:0]] <= {req_tdata[PT_W-1:COORD_W], req_tdata[COORD_W-1:0]};
      end
      prd_ff <= pmem[prd_addr];
   end

   always_ff @(posedge clock) begin
      if (swr_en) begin
         smem[depth_ff[IDX_W-1:0]] <= swr_data;
      end
      srd_ff <= smem[IDX_W'(depth_ff - CNT_W'(1))];
   end

   // shared unit: register the square sum of the current operands
   always_ff @(posedge clock) begin
      sq_ff <= SQ_W'(px_in) + SQ_W'(py_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
         escaped_ff <= 1'b0;
         jump_ff <= RST_JUMP;
         island_ff <= RST_ISLAND;
         border_ff <= RST_BORDER;
         count_ff <= '0;
         depth_ff <= '0;
         s_ff <= '0;
         t_ff <= '0;
         vis_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_JUMP:   jump_ff <= csr_wdata;
               CSR_ISLAND: island_ff <= csr_wdata;
               CSR_BORDER: border_ff <= csr_wdata;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_LOAD: begin
               // hold the answer until taken, then empty the store
               if (rsp_valid_ff && rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  count_ff <= '0;
                  depth_ff <= '0;
                  vis_ff <= '0;
               end
               if (accept) begin
                  if (pwr_en) count_ff <= count_ff + CNT_W'(1);
                  if (req_tlast) begin
                     if (reach >= {1'b0, border_ff}) begin
                        // island alone reaches the border
                        escaped_ff <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_INIT_J;
                     end
                  end
               end
            end
            ST_INIT_J: begin
               opx_ff <= OP_W'(signed'({2'b00, jump_ff}));
               opy_ff <= '0;
               state_ff <= ST_INIT_R;
            end
            ST_INIT_R: begin
               opx_ff <= OP_W'(signed'({1'b0, reach}));
               state_ff <= ST_INIT_JSQ;
            end
            ST_INIT_JSQ: begin
               jsq_ff <= sq_ff;
               state_ff <= ST_INIT_RSQ;
            end
            ST_INIT_RSQ: begin
               rsq_ff <= sq_ff;
               s_ff <= '0;
               state_ff <= ST_S_SCAN;
            end
            ST_S_SCAN: begin
               if (s_ff == count_ff) begin
                  escaped_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_LOAD;
               end else if (vis_ff[s_ff[IDX_W-1:0]]) begin
                  s_ff <= s_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_S_WAIT;
               end
            end
            ST_S_WAIT: begin
               opx_ff <= OP_W'(rd_x);
               opy_ff <= OP_W'(rd_y);
               state_ff <= ST_S_SQ;
            end
            ST_S_SQ: state_ff <= ST_S_CMP;
            ST_S_CMP: begin
               if (sq_ff <= rsq_ff) begin
                  // start candidate: mark and push it
                  vis_ff[s_ff[IDX_W-1:0]] <= 1'b1;
                  depth_ff <= CNT_W'(1);
                  state_ff <= ST_POP;
               end else begin
                  s_ff <= s_ff + CNT_W'(1);
                  state_ff <= ST_S_SCAN;
               end
            end
            ST_POP: begin
               if (depth_ff == '0) begin
                  s_ff <= s_ff + CNT_W'(1);
                  state_ff <= ST_S_SCAN;
               end else begin
                  depth_ff <= depth_ff - CNT_W'(1);
                  state_ff <= ST_POP_WAIT;
               end
            end
            ST_POP_WAIT: begin
               state_ff <= ST_POP_RD;
            end
            ST_POP_RD: begin
               ux_ff <= rd_x;
               uy_ff <= rd_y;
               t_ff <= '0;
               if (at_edge) begin
                  escaped_ff <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= ST_LOAD;
               end else begin
                  state_ff <= ST_T_SCAN;
               end
            end
            ST_T_SCAN: begin
               if (t_ff == count_ff) begin
                  state_ff <= ST_POP;
               end else if (vis_ff[t_ff[IDX_W-1:0]]) begin
                  t_ff <= t_ff + CNT_W'(1);
               end else begin
                  state_ff <= ST_T_WAIT;
               end
            end
            ST_T_WAIT: begin
               opx_ff <= OP_W'(ux_ff) - OP_W'(rd_x);
               opy_ff <= OP_W'(uy_ff) - OP_W'(rd_y);
               state_ff <= ST_T_SQ;
            end
            ST_T_SQ: state_ff <= ST_T_CMP;
            ST_T_CMP: begin
               if (swr_en) begin
                  vis_ff[t_ff[IDX_W-1:0]] <= 1'b1;
                  depth_ff <= depth_ff + CNT_W'(1);
               end
               t_ff <= t_ff + CNT_W'(1);
               state_ff <= ST_T_SCAN;
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule
